FILE: rtl/core/bipr_pkg.sv
package bipr_pkg;

	// default sizes for the line memory and the row counter
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	// configuration register widths and reset values
	localparam int unsigned CFG_W_BITS = 11;
	localparam int unsigned CFG_H_BITS = 13;
	localparam int unsigned RST_WIDTH  = 64;
	localparam int unsigned RST_HEIGHT = 64;

	// register select, taken from the word address bit of paddr
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// output queue depth
	localparam int unsigned FIFO_DEPTH = 4;

	// one line memory word: the column's pixel two rows back and one row back
	typedef struct packed {
		logic middle;
		logic upper;
	} line_word_t;

	// one result
	typedef struct packed {
		logic pixel;
		logic last;
	} out_item_t;

	// columns carry bit 0 = upper row, bit 1 = centre row, bit 2 = lower row
	function automatic logic filter_center(input logic [2:0] left, input logic [2:0] mid,
		input logic [2:0] right, input logic top_ok, input logic bot_ok,
		input logic left_ok, input logic right_ok);
		logic [2:0] rows;
		logic [2:0] neigh;
		rows  = {bot_ok, 1'b1, top_ok};
		neigh = mid & rows & 3'b101;
		if (left_ok) neigh = neigh | (left & rows);
		if (right_ok) neigh = neigh | (right & rows);
		return mid[1] & (neigh != 3'b000);
	endfunction

endpackage

FILE: rtl/core/bipr_line_mem.sv
module bipr_line_mem #(
	parameter int unsigned DEPTH = bipr_pkg::DEF_MAX_WIDTH,
	parameter int unsigned AW    = $clog2(bipr_pkg::DEF_MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  bipr_pkg::line_word_t wr_data,
	input  logic [AW-1:0]        rd_addr,
	output bipr_pkg::line_word_t rd_data
);

	bipr_pkg::line_word_t mem [DEPTH];

	// one write and one registered read per cycle, read returns old data on collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/bipr_out_fifo.sv
module bipr_out_fifo (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          push,
	input  bipr_pkg::out_item_t                           din,
	output logic                                          valid,
	input  logic                                          ready,
	output bipr_pkg::out_item_t                           dout,
	output logic [$clog2(bipr_pkg::FIFO_DEPTH + 1)-1:0]   count
);

	localparam int unsigned PW = $clog2(bipr_pkg::FIFO_DEPTH);
	localparam int unsigned CW = $clog2(bipr_pkg::FIFO_DEPTH + 1);

	bipr_pkg::out_item_t entries_q [bipr_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign valid = (count_q != '0);
	assign pop   = valid & ready;
	assign dout  = entries_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/binary_isolated_pixel_removal_core.sv
// Isolated pixel removal for a binary mask streamed in raster order, one pixel per
// transfer. A set pixel whose in-frame 3x3 neighbours are all clear leaves as 0; every
// other pixel passes unchanged, and neighbours outside the image count as clear.
// s_tdata[0] carries the mask bit, s_tuser = 1 marks a drain transfer that pushes out
// the frame tail; each result lags its input by one row plus one pixel, the first
// width + 1 transfers of a frame give no result, and m_tlast flags the frame's final
// pixel. Pixels that arrive once the frame is full, and drains sent before it is full,
// are taken and dropped without a result. Width and height are written over APB at
// byte addresses 0 and 4, by the user only while the stream is idle (not enforced by
// the block), and are saturated to [2, MAX_WIDTH] and [2, MAX_HEIGHT]. The block
// takes one transfer per clock while s_tready is high: the two previous rows sit in
// one line memory that is read at the incoming column and written back in the next
// cycle, one column per cycle. After reset a clearing pass zeroes the line memory,
// and s_tready stays low meanwhile. A result passes the stage register into a small
// output queue that drives m_tvalid and lets input flow while the sink stalls briefly.
module binary_isolated_pixel_removal_core #(
	parameter int unsigned MAX_WIDTH  = bipr_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bipr_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pixel_in, [7:1] zero
	input  logic        s_tuser,   // [0] command
	// filtered output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] pixel_out, [7:1] zero
	output logic        m_tlast    // last_of_frame
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
	localparam int unsigned CW = $clog2(bipr_pkg::FIFO_DEPTH + 1);

	// per-transfer control carried into the second stage
	typedef struct packed {
		logic [AW-1:0] addr;
		logic          pixel;
		logic          br0;    // centre is the last column of the row two back
		logic          br1;    // centre is the previous column of the row above
		logic          last;
		logic          top0;
		logic          bot0;
		logic          top1;
		logic          bot1;
		logic          left1;
	} s1_ctl_t;

	// configuration registers
	logic [bipr_pkg::CFG_W_BITS-1:0] image_width_q;
	logic [bipr_pkg::CFG_H_BITS-1:0] image_height_q;
	logic                            cfg_wr;

	// effective sizes
	logic [bipr_pkg::CFG_W_BITS-1:0] w_eff;
	logic [bipr_pkg::CFG_H_BITS-1:0] h_eff;

	// raster position of the next transfer
	logic [AW-1:0] in_column_q;
	logic [RW-1:0] in_row_q;

	// line memory clearing pass
	logic [AW-1:0] clr_q;
	logic          clr_done_q;

	// first stage decode
	logic [31:0] col32;
	logic [31:0] row32;
	logic [31:0] w32;
	logic [31:0] h32;
	logic        drain;
	logic        full;
	logic        take;
	logic        br0;
	logic        br1;
	logic        last;
	logic        row_end;
	logic        acc;
	logic        go;

	// second stage
	logic                 s1_valid;
	s1_ctl_t              ctl_s1;
	logic                 fwd_s1;
	bipr_pkg::line_word_t fwd_word_s1;
	bipr_pkg::line_word_t mem_rdata;
	bipr_pkg::line_word_t rd_word;
	bipr_pkg::line_word_t wr_word;
	logic [8:0]           win_q;
	logic [8:0]           new_win;
	logic                 pix0;
	logic                 pix1;
	logic                 push;
	bipr_pkg::out_item_t  push_item;

	// line memory ports
	logic                 mem_wr_en;
	logic [AW-1:0]        mem_wr_addr;
	bipr_pkg::line_word_t mem_wr_data;

	// output queue
	bipr_pkg::out_item_t fifo_dout;
	logic [CW-1:0]       fifo_cnt;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bipr_pkg::CFG_W_BITS'(bipr_pkg::RST_WIDTH);
			image_height_q <= bipr_pkg::CFG_H_BITS'(bipr_pkg::RST_HEIGHT);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bipr_pkg::REG_WIDTH:  image_width_q  <= pwdata[bipr_pkg::CFG_W_BITS-1:0];
				bipr_pkg::REG_HEIGHT: image_height_q <= pwdata[bipr_pkg::CFG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			bipr_pkg::REG_WIDTH:  prdata = 32'(image_width_q);
			bipr_pkg::REG_HEIGHT: prdata = 32'(image_height_q);
			default:              prdata = '0;
		endcase
	end

	// saturate the sizes into their working range
	always_comb begin
		if (image_width_q < bipr_pkg::CFG_W_BITS'(2)) begin
			w_eff = bipr_pkg::CFG_W_BITS'(2);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = bipr_pkg::CFG_W_BITS'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q < bipr_pkg::CFG_H_BITS'(2)) begin
			h_eff = bipr_pkg::CFG_H_BITS'(2);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_eff = bipr_pkg::CFG_H_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	// ---------------------------------------------------------------- first stage
	assign col32 = 32'(in_column_q);
	assign row32 = 32'(in_row_q);
	assign w32   = 32'(w_eff);
	assign h32   = 32'(h_eff);

	assign drain   = s_tuser;
	assign full    = (row32 >= h32);
	// pixels go in until the frame is full, drains only after
	assign take    = (drain == full);
	assign br0     = (col32 == 32'd0) && (row32 >= 32'd2);
	assign br1     = (col32 != 32'd0) && (row32 >= 32'd1);
	// the drain that emits past the last row closes the frame
	assign last    = drain && (row32 >= h32 + 32'd1) && (br0 || br1);
	assign row_end = (col32 >= w32 - 32'd1);

	// a free slot for every result that may still be on its way
	assign s_tready = clr_done_q &&
		((32'(fifo_cnt) + 32'(s1_valid)) <= (bipr_pkg::FIFO_DEPTH - 2));
	assign acc = s_tvalid & s_tready;
	assign go  = acc & take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q    <= '0;
		end else if (go) begin
			if (last) begin
				in_column_q <= '0;
				in_row_q    <= '0;
			end else if (row_end) begin
				in_column_q <= '0;
				in_row_q    <= RW'(row32 + 32'd1);
			end else begin
				in_column_q <= in_column_q + AW'(1);
			end
		end
	end

	// stage register, only transfers that are not dropped move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			s1_valid <= go;
			// back-to-back access to one column (frame restart at column zero)
			if (go) fwd_s1 <= s1_valid && (ctl_s1.addr == in_column_q);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ctl_s1.addr  <= in_column_q;
			ctl_s1.pixel <= drain ? 1'b0 : s_tdata[0];
			ctl_s1.br0   <= br0;
			ctl_s1.br1   <= br1;
			ctl_s1.last  <= last;
			ctl_s1.top0  <= (row32 >= 32'd3);
			ctl_s1.bot0  <= (row32 < h32 + 32'd1);
			ctl_s1.top1  <= (row32 >= 32'd2);
			ctl_s1.bot1  <= (row32 < h32);
			ctl_s1.left1 <= (col32 >= 32'd2);
			fwd_word_s1  <= wr_word;
		end
	end

	// ---------------------------------------------------------------- line memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (32'(clr_q) == MAX_WIDTH - 1) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	assign mem_wr_en   = !clr_done_q || s1_valid;
	assign mem_wr_addr = clr_done_q ? ctl_s1.addr : clr_q;
	assign mem_wr_data = clr_done_q ? wr_word : '0;

	bipr_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (in_column_q),
		.rd_data (mem_rdata)
	);

	// ---------------------------------------------------------------- second stage
	assign rd_word = fwd_s1 ? fwd_word_s1 : mem_rdata;

	// rows move up by one: old middle becomes upper, the new pixel becomes middle
	assign wr_word.middle = ctl_s1.pixel;
	assign wr_word.upper  = rd_word.middle;

	// newest column in the low bits
	assign new_win = {win_q[5:0], ctl_s1.pixel, rd_word.middle, rd_word.upper};

	// row wrap: centre is the old newest column, no right neighbour
	assign pix0 = bipr_pkg::filter_center(win_q[5:3], win_q[2:0], 3'b000,
		ctl_s1.top0, ctl_s1.bot0, 1'b1, 1'b0);
	// inside a row: centre is the middle column of the updated window
	assign pix1 = bipr_pkg::filter_center(new_win[8:6], new_win[5:3], new_win[2:0],
		ctl_s1.top1, ctl_s1.bot1, ctl_s1.left1, 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_valid) begin
			win_q <= new_win;
		end
	end

	assign push            = s1_valid && (ctl_s1.br0 || ctl_s1.br1);
	assign push_item.pixel = ctl_s1.br0 ? pix0 : pix1;
	assign push_item.last  = ctl_s1.last;

	// ---------------------------------------------------------------- output
	bipr_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (fifo_dout),
		.count  (fifo_cnt)
	);

	assign m_tdata = {7'b0000000, fifo_dout.pixel};
	assign m_tlast = fifo_dout.last;

	// ---------------------------------------------------------------- checks
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(fifo_cnt) < bipr_pkg::FIFO_DEPTH))
		else $error("result pushed into a full output queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !s1_valid)
		else $error("transfer in flight during line memory clearing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(go && last) |=> ((in_column_q == '0) && (in_row_q == '0)))
		else $error("frame end did not return the raster position to zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_column_q) < MAX_WIDTH)
		else $error("column counter beyond line memory depth");

endmodule

FILE: tb/binary_isolated_pixel_removal_core_test.sv
`timescale 1ns / 100ps

module binary_isolated_pixel_removal_core_test;

	localparam int unsigned MAX_W       = bipr_pkg::DEF_MAX_WIDTH;
	localparam int unsigned MAX_H       = bipr_pkg::DEF_MAX_HEIGHT;
	localparam int unsigned ITEM_TARGET = 1250;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned PLAN_LEN    = 30;
	localparam int unsigned MIN_PHASES  = 8;

	// s_tuser values
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// how the two sides pause during a phase
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_SLOW,
		PACE_SINK_SLOW,
		PACE_BOTH
	} pace_t;

	// directed rows either write a register or send one transfer
	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// where the expected result of a directed transfer comes from
	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_NONE,
		CHECK_TYPED
	} check_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        sel;
		logic [31:0] value;
		logic        cmd;
		logic        px;
		check_t      check;
		logic        e_pix;
		logic        e_lof;
	} directed_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [0] pixel_in, [7:1] zero
	logic        s_tuser  = 1'b0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [0] pixel_out, [7:1] zero
	logic        m_tlast;           // last_of_frame

	pace_t pace = PACE_FULL;
	int    fault_count = 0;

	// filtered pixels still owed by the block, oldest first
	bipr_pkg::out_item_t pending_pixels [$];
	bipr_pkg::out_item_t due;

	// own copy of the filter state
	logic        upper_bits  [MAX_W];
	logic        middle_bits [MAX_W];
	logic [8:0]  win_bits;
	int unsigned pos_col;
	int unsigned pos_row;
	logic [10:0] cfg_width;
	logic [12:0] cfg_height;

	// directed part: corner cases on tiny frames
	directed_row_t plan [PLAN_LEN] = '{
		// drain while the default frame is still empty is ignored
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		// zero in both registers saturates to a 2x2 frame
		'{ROW_CFG, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_CFG, bipr_pkg::REG_HEIGHT, 32'd0, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		// lone set pixel in the top left corner, first W + 1 transfers give nothing
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_TYPED, 1'b0, 1'b0},
		// pixel once the frame is full is dropped
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_TYPED, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_TYPED, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_TYPED, 1'b0, 1'b1},
		// solid frame, nothing is isolated
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		// 3x2 frame with isolated pixels in opposite corners, right column included
		'{ROW_CFG, bipr_pkg::REG_WIDTH, 32'd3, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_CFG, bipr_pkg::REG_HEIGHT, 32'd2, CMD_PIXEL, 1'b0, CHECK_NONE, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_PIXEL, 1'b1, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0},
		'{ROW_ITEM, bipr_pkg::REG_WIDTH, 32'd0, CMD_DRAIN, 1'b0, CHECK_MODEL, 1'b0, 1'b0}
	};

	binary_isolated_pixel_removal_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the stream hangs
	initial begin
		#2_000_000;
		$display("binary_isolated_pixel_removal_core_test: errors");
		$finish;
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned lo,
		int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// columns: bit 0 upper row, bit 1 centre row, bit 2 lower row
	function automatic logic keeps_pixel(logic [2:0] lcol, logic [2:0] mcol,
		logic [2:0] rcol, logic top_ok, logic bot_ok, logic left_ok, logic right_ok);
		logic [2:0] rows;
		logic [2:0] lit;
		rows = {bot_ok, 1'b1, top_ok};
		lit  = mcol & rows & 3'b101;
		if (left_ok) lit = lit | (lcol & rows);
		if (right_ok) lit = lit | (rcol & rows);
		return mcol[1] && (lit != 3'b000);
	endfunction

	// queue one pixel that the block still owes
	task automatic owe_pixel(input bipr_pkg::out_item_t item);
		pending_pixels = {pending_pixels, item};
	endtask

	task automatic clear_filter_state();
		for (int i = 0; i < MAX_W; i++) begin
			upper_bits[i]  = 1'b0;
			middle_bits[i] = 1'b0;
		end
		win_bits   = '0;
		pos_col    = 0;
		pos_row    = 0;
		cfg_width  = bipr_pkg::CFG_W_BITS'(bipr_pkg::RST_WIDTH);
		cfg_height = bipr_pkg::CFG_H_BITS'(bipr_pkg::RST_HEIGHT);
	endtask

	// advance the filter by one accepted transfer; counted is low when it is ignored
	task automatic filter_mask_pixel(input logic drain_cmd, input logic px,
		output bit counted, output bit produced, output bipr_pkg::out_item_t res);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		logic        v;
		logic        u;
		logic        m;
		logic        pix;
		logic        full;
		w        = clamp_size(32'(cfg_width), 2, MAX_W);
		h        = clamp_size(32'(cfg_height), 2, MAX_H);
		v        = drain_cmd ? 1'b0 : px;
		c        = pos_col;
		r        = pos_row;
		full     = (r >= h);
		pix      = 1'b0;
		produced = 0;
		res      = '0;
		counted  = (drain_cmd == full);
		if (!counted) return;
		// start of a row: the last column of the row two back is complete
		if (c == 0 && r >= 2) begin
			pix      = keeps_pixel(win_bits[5:3], win_bits[2:0], 3'b000, r >= 3, r - 1 < h,
				1'b1, 1'b0);
			produced = 1;
		end
		if (c < MAX_W) begin
			u              = upper_bits[c];
			m              = middle_bits[c];
			upper_bits[c]  = m;
			middle_bits[c] = v;
			win_bits       = {win_bits[5:0], v, m, u};
		end
		if (c >= 1 && r >= 1) begin
			pix      = keeps_pixel(win_bits[8:6], win_bits[5:3], win_bits[2:0], r >= 2, r < h,
				c >= 2, 1'b1);
			produced = 1;
		end
		if (c >= w - 1) begin
			pos_col = 0;
			pos_row = r + 1;
		end else begin
			pos_col = c + 1;
		end
		if (!produced) return;
		res.pixel = pix;
		res.last  = drain_cmd && (r >= h + 1);
		if (res.last) begin
			pos_col = 0;
			pos_row = 0;
		end
	endtask

	function automatic bit source_rests();
		case (pace)
			PACE_SRC_SLOW: return $urandom_range(99) < 75;
			PACE_BOTH:     return $urandom_range(99) < 14;
			default:       return 0;
		endcase
	endfunction

	function automatic bit sink_takes();
		case (pace)
			PACE_SINK_SLOW: return $urandom_range(99) >= 75;
			PACE_BOTH:      return $urandom_range(99) >= 14;
			default:        return 1;
		endcase
	endfunction

	// one transfer on the pixel input, then advance the filter copy
	task automatic send_mask_item(input logic drain_cmd, input logic px,
		output bit counted, output bit produced, output bipr_pkg::out_item_t res);
		while (source_rests()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, px};
		s_tuser  <= drain_cmd;
		do @(posedge clk); while (!s_tready);
		filter_mask_pixel(drain_cmd, px, counted, produced, res);
	endtask

	// stop sending and wait until every owed pixel has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// apb write, then read back the same register
	task automatic write_reg(input logic sel, input logic [31:0] value);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == bipr_pkg::REG_WIDTH) begin
			cfg_width = value[bipr_pkg::CFG_W_BITS-1:0];
			want      = {21'd0, value[bipr_pkg::CFG_W_BITS-1:0]};
		end else begin
			cfg_height = value[bipr_pkg::CFG_H_BITS-1:0];
			want       = {19'd0, value[bipr_pkg::CFG_H_BITS-1:0]};
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("%s: expected %0d, got %0d",
				sel == bipr_pkg::REG_WIDTH ? "image_width" : "image_height", want, prdata);
			fault_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic int unsigned pick_width();
		case ($urandom_range(9))
			0:       return $urandom_range(1, 0);
			1:       return $urandom_range(32, 11);
			default: return $urandom_range(10, 2);
		endcase
	endfunction

	function automatic int unsigned pick_height();
		case ($urandom_range(9))
			0:       return $urandom_range(1, 0);
			1:       return $urandom_range(16, 9);
			default: return $urandom_range(8, 2);
		endcase
	endfunction

	// sink side stalls follow the current pace
	always @(posedge clk) begin
		m_tready <= sink_takes();
	end

	// compare every output transfer with the oldest owed pixel
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected transfer: pixel_out %0d, last_of_frame %0d", m_tdata[0],
					m_tlast);
				fault_count++;
			end else begin
				due = pending_pixels.pop_front();
				if (m_tdata[0] !== due.pixel) begin
					$error("pixel_out: expected %0d, got %0d", due.pixel, m_tdata[0]);
					fault_count++;
				end
				if (m_tlast !== due.last) begin
					$error("last_of_frame: expected %0d, got %0d", due.last, m_tlast);
					fault_count++;
				end
			end
		end
	end

	initial begin
		bipr_pkg::out_item_t res;
		bit                  counted;
		bit                  produced;
		logic                drain_cmd;
		logic                px;
		int unsigned         sent_items;
		int unsigned         phase;
		int unsigned         span;
		int unsigned         done;
		int unsigned         density;
		sent_items = 0;
		phase      = 0;
		clear_filter_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows at full rate
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].sel, plan[i].value);
			end else begin
				send_mask_item(plan[i].cmd, plan[i].px, counted, produced, res);
				case (plan[i].check)
					CHECK_MODEL: if (produced) owe_pixel(res);
					CHECK_TYPED: owe_pixel(bipr_pkg::out_item_t'{pixel: plan[i].e_pix,
						last: plan[i].e_lof});
					default: ;
				endcase
			end
		end
		settle();

		// random phases, pacing rotates so every mode is seen several times
		while ((sent_items < ITEM_TARGET) || (phase < MIN_PHASES)) begin
			pace = pace_t'(phase % 4);
			span = $urandom_range(40, 12);
			case ($urandom_range(3))
				0:       density = 6;
				1:       density = 25;
				2:       density = 50;
				default: density = 90;
			endcase
			case (phase)
				// widest row: one full row plus a few columns of the next
				2: begin
					write_reg(bipr_pkg::REG_WIDTH, 32'd2047);
					write_reg(bipr_pkg::REG_HEIGHT, 32'd8191);
					span = MAX_W + 6;
				end
				// shrink mid-frame: the current column is past the new last one
				3: begin
					write_reg(bipr_pkg::REG_WIDTH, 32'd5);
					write_reg(bipr_pkg::REG_HEIGHT, 32'd3);
				end
				// tallest frame, narrow rows
				6: begin
					write_reg(bipr_pkg::REG_WIDTH, 32'd2);
					write_reg(bipr_pkg::REG_HEIGHT, 32'd8191);
					span = 60;
				end
				// row is now far past the height, next drain ends the frame
				7: write_reg(bipr_pkg::REG_HEIGHT, 32'd4);
				default: begin
					if ($urandom_range(9) < 7) begin
						write_reg(bipr_pkg::REG_WIDTH, pick_width());
						write_reg(bipr_pkg::REG_HEIGHT, pick_height());
					end
				end
			endcase
			done = 0;
			while (done < span) begin
				// mostly well-formed frames, with stray drains and late pixels mixed in
				if (pos_row < clamp_size(32'(cfg_height), 2, MAX_H))
					drain_cmd = ($urandom_range(99) < 4) ? CMD_DRAIN : CMD_PIXEL;
				else
					drain_cmd = ($urandom_range(99) < 8) ? CMD_PIXEL : CMD_DRAIN;
				px = ($urandom_range(99) < density);
				send_mask_item(drain_cmd, px, counted, produced, res);
				if (produced) owe_pixel(res);
				if (counted) done++;
			end
			sent_items += done;
			settle();
			phase++;
		end

		if (fault_count == 0) begin
			$display("binary_isolated_pixel_removal_core_test: clean");
		end else begin
			$display("binary_isolated_pixel_removal_core_test: errors");
		end
		$finish;
	end

endmodule
